// ===== rtl/ptsp_pkg.sv =====
// ----------------------------------------------------------------------------
// ptsp_pkg: shared types and constants
// Character codes, matcher states, capture store type and decimal helpers
// for the play time status parser.
// ----------------------------------------------------------------------------
package ptsp_pkg;

    localparam int STORE_DEPTH        = 34;
    localparam int PTR_LIMIT          = 33;
    localparam int CAPTURE_LENGTH_DEF = 32;
    localparam int PTR_W              = 6;
    localparam int SEC_W              = 13;
    localparam int FIELD_W            = 7;

    localparam logic [7:0] CH_T     = 8'h54;  // 'T'
    localparam logic [7:0] CH_I     = 8'h69;  // 'i'
    localparam logic [7:0] CH_M     = 8'h6d;  // 'm'
    localparam logic [7:0] CH_E     = 8'h65;  // 'e'
    localparam logic [7:0] CH_COLON = 8'h3a;  // ':'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    // keyword matcher states
    localparam logic [2:0] MS_IDLE    = 3'd0;
    localparam logic [2:0] MS_T       = 3'd1;
    localparam logic [2:0] MS_TI      = 3'd2;
    localparam logic [2:0] MS_TIM     = 3'd3;
    localparam logic [2:0] MS_TIME    = 3'd4;
    localparam logic [2:0] MS_KEYWORD = 3'd5;
    localparam logic [2:0] MS_CAPTURE = 3'd6;

    typedef logic [STORE_DEPTH-1:0][7:0] store_t;

    typedef struct packed {
        logic valid;   // decode request pending
        logic run;     // sequence running flag of the completing byte
    } dec_req_t;

    // digit value of a character, zero when not '0'..'9'
    function automatic logic [3:0] digit_val(input logic [7:0] c);
        logic [7:0] d;
        d = c - CH_ZERO;
        return (c >= CH_ZERO && c <= CH_NINE) ? d[3:0] : 4'd0;
    endfunction

    function automatic logic [FIELD_W-1:0] two_digits(input logic [7:0] hi,
                                                       input logic [7:0] lo);
        return FIELD_W'(digit_val(hi)) * FIELD_W'(10) + FIELD_W'(digit_val(lo));
    endfunction

endpackage

// ===== rtl/ptsp_result.sv =====
// ----------------------------------------------------------------------------
// ptsp_result: field decode and result register
// Decodes the two-digit fields of a finished capture, tracks the last synced
// second and holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ptsp_result (
    input  logic              clk,
    input  logic              rst_n,
    input  ptsp_pkg::dec_req_t req,
    input  ptsp_pkg::store_t   store,
    output logic              out_free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [55:0]       m_tdata,   // elapsed_seconds, elapsed_hundredths,
                                         // remaining_seconds, remaining_hundredths,
                                         // total_minutes, total_secs_field, pad
    output logic              m_tuser    // sync_now
);

    logic                              valid_reg;
    logic [55:0]                       data_reg;
    logic                              sync_reg;
    logic [ptsp_pkg::SEC_W-1:0]        last_sync_reg;
    logic [ptsp_pkg::SEC_W-1:0]        last_sync_next;

    logic                              load;
    logic [ptsp_pkg::FIELD_W-1:0]      el_min, el_sec, el_hun;
    logic [ptsp_pkg::FIELD_W-1:0]      rm_min, rm_sec, rm_hun;
    logic [ptsp_pkg::FIELD_W-1:0]      tot_min, tot_sec;
    logic [ptsp_pkg::SEC_W-1:0]        el_total, rm_total;
    logic                              sync;

    assign out_free = !valid_reg || m_tready;
    assign load     = req.valid && out_free;

    always_comb
    begin
        el_min  = ptsp_pkg::two_digits(store[1],  store[2]);
        el_sec  = ptsp_pkg::two_digits(store[4],  store[5]);
        el_hun  = ptsp_pkg::two_digits(store[7],  store[8]);
        rm_min  = ptsp_pkg::two_digits(store[11], store[12]);
        rm_sec  = ptsp_pkg::two_digits(store[14], store[15]);
        rm_hun  = ptsp_pkg::two_digits(store[17], store[18]);
        tot_min = ptsp_pkg::two_digits(store[24], store[25]);
        tot_sec = ptsp_pkg::two_digits(store[27], store[28]);

        el_total = ptsp_pkg::SEC_W'(el_min) * ptsp_pkg::SEC_W'(60)
                 + ptsp_pkg::SEC_W'(el_sec);
        rm_total = ptsp_pkg::SEC_W'(rm_min) * ptsp_pkg::SEC_W'(60)
                 + ptsp_pkg::SEC_W'(rm_sec);

        sync = req.run && (el_total != '0) && (el_total != last_sync_reg);
        last_sync_next = (load && sync) ? el_total : last_sync_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            last_sync_reg <= '0;
        end
        else
        begin
            last_sync_reg <= last_sync_next;
            if (load)
                valid_reg <= 1'b1;
            else if (m_tready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {2'b00, tot_sec, tot_min, rm_hun, rm_total, el_hun, el_total};
            sync_reg <= sync;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = sync_reg;

endmodule

// ===== rtl/play_time_status_parser.sv =====
// ----------------------------------------------------------------------------
// play_time_status_parser: status text time parser
// Finds the "Time:" keyword in a byte stream, captures the time text and
// returns decoded elapsed, remaining and total times.
// ----------------------------------------------------------------------------
// Takes one character per cycle on the slave stream, with no dead cycles
// while s_tready is high. The keyword matcher and capture store update in the
// cycle a byte is accepted; the byte that completes a capture raises a decode
// request, which is registered and then decoded into the result register. The
// slave side stalls only while a decoded result is waiting in the result
// register and the master side is not taking it. At most one result per
// captured record; all other bytes produce no result.
module play_time_status_parser #(
    parameter int CAPTURE_LENGTH = ptsp_pkg::CAPTURE_LENGTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte
    input  logic [1:0]  s_tuser,   // chunk_start, sequence_running
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // elapsed_seconds[12:0], elapsed_hundredths[19:13],
                                   // remaining_seconds[32:20], remaining_hundredths[39:33],
                                   // total_minutes[46:40], total_secs_field[53:47]
    output logic        m_tuser    // sync_now
);

    logic [2:0]                   state_reg, state_next;
    logic [ptsp_pkg::PTR_W-1:0]   ptr_reg, ptr_next;
    ptsp_pkg::store_t             store_reg;
    ptsp_pkg::dec_req_t           req_reg, req_next;

    logic                         accept;
    logic                         out_free;
    logic [2:0]                   s0;
    logic [ptsp_pkg::PTR_W-1:0]   p0, p_wr, p_inc;
    logic                         wr_en;
    logic                         done;

    assign s_tready = !req_reg.valid || out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        s0    = s_tuser[0] ? ptsp_pkg::MS_IDLE : state_reg;
        p0    = s_tuser[0] ? '0 : ptr_reg;
        state_next = s0;
        ptr_next   = p0;
        p_wr  = p0;
        wr_en = 1'b0;
        done  = 1'b0;

        unique case (s_tdata)
            ptsp_pkg::CH_T:
                state_next = ptsp_pkg::MS_T;
            ptsp_pkg::CH_I:
                state_next = (s0 == ptsp_pkg::MS_T) ? ptsp_pkg::MS_TI : ptsp_pkg::MS_IDLE;
            ptsp_pkg::CH_M:
                state_next = (s0 == ptsp_pkg::MS_TI) ? ptsp_pkg::MS_TIM : ptsp_pkg::MS_IDLE;
            ptsp_pkg::CH_E:
                state_next = (s0 == ptsp_pkg::MS_TIM) ? ptsp_pkg::MS_TIME : ptsp_pkg::MS_IDLE;
            ptsp_pkg::CH_COLON:
            begin
                if (s0 == ptsp_pkg::MS_TIME)
                    state_next = ptsp_pkg::MS_KEYWORD;
                else if (p0 != '0)
                    wr_en = 1'b1;   // stray colon joins a running capture
            end
            default:
            begin
                // first byte after the keyword restarts the capture
                if (s0 == ptsp_pkg::MS_KEYWORD)
                begin
                    p_wr       = '0;
                    state_next = ptsp_pkg::MS_CAPTURE;
                end
                if (s0 == ptsp_pkg::MS_KEYWORD || s0 == ptsp_pkg::MS_CAPTURE)
                    wr_en = 1'b1;
            end
        endcase

        p_inc = (p_wr == ptsp_pkg::PTR_W'(ptsp_pkg::PTR_LIMIT)) ? p_wr : p_wr + 1'b1;
        if (wr_en)
            ptr_next = p_inc;

        // only the ordinary capture path completes a record
        if (wr_en && s_tdata != ptsp_pkg::CH_COLON
            && p_inc == ptsp_pkg::PTR_W'(CAPTURE_LENGTH))
        begin
            done       = 1'b1;
            ptr_next   = '0;
            state_next = ptsp_pkg::MS_IDLE;
        end

        if (accept && done)
        begin
            req_next.valid = 1'b1;
            req_next.run   = s_tuser[1];
        end
        else
        begin
            req_next.valid = req_reg.valid && !out_free;
            req_next.run   = req_reg.run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptsp_pkg::MS_IDLE;
            ptr_reg   <= '0;
            req_reg   <= '0;
        end
        else
        begin
            req_reg <= req_next;
            if (accept)
            begin
                state_reg <= state_next;
                ptr_reg   <= ptr_next;
            end
        end
    end

    // every decoded entry is written by the capture that decodes it
    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
            store_reg[p_wr] <= s_tdata;
    end

    ptsp_result u_result (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_reg),
        .store    (store_reg),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/ptsp_checker.sv =====
// ----------------------------------------------------------------------------
// ptsp_checker: port-level checks
// Watches the top-level ports of the status parser for stall, range and
// sync flag consistency.
// ----------------------------------------------------------------------------
module ptsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tuser
);

    // a held result must not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // input stalls only behind a blocked result
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // sync request needs a nonzero elapsed time
    a_sync: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[12:0] != 13'd0)
        else $error("sync request with zero elapsed time");

    // decoded fields stay in their decimal range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[12:0] <= 13'd6039 && m_tdata[19:13] <= 7'd99
                  && m_tdata[32:20] <= 13'd6039 && m_tdata[39:33] <= 7'd99
                  && m_tdata[46:40] <= 7'd99 && m_tdata[53:47] <= 7'd99
                  && m_tdata[55:54] == 2'b00)
        else $error("decoded field out of range");

endmodule

bind play_time_status_parser ptsp_checker u_ptsp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
